[rtl/core/assert_macros.svh]
// assertion macros used by the checker file btot_chk.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define BTOT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define BTOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/btot_pkg.sv]
// types, constants and control bundles for the backlash offset table
// no dependencies
package btot_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int TIME_W  = 48;
    localparam int TGT_W   = 32;
    localparam int RAMP_W  = 20;
    localparam int SM_BITS = 30;
    localparam int DCNT_W  = $clog2(SM_BITS + 1);

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        RD_TOP      = 2'd0,
        RD_BELOW    = 2'd1,
        RD_NEXT_TOP = 2'd2,
        RD_SECOND   = 2'd3
    } rd_sel_t;

    typedef struct packed {
        logic signed [TGT_W-1:0] target;
        logic [TIME_W-1:0]       tstamp;
        logic [RAMP_W-1:0]       ramp;
    } entry_t;

    typedef struct packed {
        logic    latch_item;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    k_top;
        logic    k_dec;
        logic    cur_load;
        logic    prv_load;
        logic    off_from_rd;
        logic    off_from_prv;
        logic    div_start;
        logic    u_load;
        logic    u2_load;
        logic    sm_load;
        logic    prod_load;
        logic    off_blend;
        logic    ramp_short;
        logic    cnt_dec;
        logic    drop_old;
        logic    set_dropped;
        logic    write_new;
        logic    clear_tab;
        logic    out_load;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       dflt_zero;
        logic       k_zero;
        logic       rd_after;
        logic       tgt_eq;
        logic       dt_ge_r;
        logic       cnt_le1;
        logic       mrg_stop;
        logic       mrg_flushed;
        logic       prune;
        logic       full;
        logic       div_done;
        logic       out_free;
    } stat_t;

endpackage

[rtl/core/backlash_takeup_offset_table.sv]
// top level of the backlash take-up offset table
// depends on btot_pkg, btot_ctrl, btot_dp
//
// usage:
//   s_axis carries one command beat: tuser = cmd (0 query, 1 insert, 2 clear),
//   tdata = event_time, new_target, ramp_time, flush_time from bit 0 up.
//   m_axis returns exactly one beat per command: offset, dropped, entries.
//   cfg_we/cfg_wdata write default_ramp_us; write only while no command is open.
// command flow:
//   one command at a time; s_axis_tready is high only while the sequencer idles.
//   clear and unused codes go straight to the result; insert stops at an
//   unchanged target, else merges, prunes old entries and writes the new one;
//   query returns zero with default_ramp_us zero, else walks back over up to 15
//   older milestones and may blend through the bit-serial divider.
// reset:
//   table holds one zero milestone, default_ramp_us is zero, no beat pending.
// stall:
//   a result waits in the output register while m_axis_tready is low; the next
//   command is still accepted and runs until its own result needs the register.
module backlash_takeup_offset_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [19:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [151:0] s_axis_tdata,  // event_time, new_target, ramp_time, flush_time, pad
    input  logic [1:0]   s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata   // offset, dropped, entries, pad
);

    btot_pkg::ctrl_t ctl;
    btot_pkg::stat_t st;
    logic signed [btot_pkg::TGT_W-1:0] out_offset;
    logic                              out_dropped;
    logic [btot_pkg::CNT_W-1:0]        out_entries;

    btot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .ctl      (ctl)
    );

    btot_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_cmd      (s_axis_tuser),
        .in_time     (s_axis_tdata[47:0]),
        .in_target   (s_axis_tdata[79:48]),
        .in_ramp     (s_axis_tdata[99:80]),
        .in_flush    (s_axis_tdata[147:100]),
        .ctl         (ctl),
        .st          (st),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_offset  (out_offset),
        .out_dropped (out_dropped),
        .out_entries (out_entries)
    );

    assign m_axis_tdata = {2'b00, out_entries, out_dropped, out_offset};

endmodule

[rtl/core/btot_div.sv]
// restoring divider for the smoothstep fraction, one quotient bit per cycle
// depends on btot_pkg
module btot_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [btot_pkg::RAMP_W-1:0]       num,
    input  logic [btot_pkg::RAMP_W-1:0]       den,
    output logic                              busy,
    output logic [btot_pkg::SM_BITS-1:0]      quot
);

    logic                              busy_reg, busy_next;
    logic [btot_pkg::DCNT_W-1:0]       cnt_reg, cnt_next;
    logic [btot_pkg::RAMP_W:0]         rem_reg, rem_next;
    logic [btot_pkg::RAMP_W-1:0]       den_reg, den_next;
    logic [btot_pkg::SM_BITS-1:0]      quot_reg, quot_next;
    logic [btot_pkg::RAMP_W:0]         rem_sh;
    logic                              ge;

    always_comb
    begin
        rem_sh    = {rem_reg[btot_pkg::RAMP_W-1:0], 1'b0};
        ge        = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = btot_pkg::DCNT_W'(btot_pkg::SM_BITS);
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            quot_next = {quot_reg[btot_pkg::SM_BITS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == btot_pkg::DCNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

[rtl/core/btot_ctrl.sv]
// sequencer for query, insert and clear commands
// depends on btot_pkg
module btot_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  btot_pkg::stat_t   st,
    output btot_pkg::ctrl_t   ctl
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_DISP   = 17'h00002,
        S_LK_CHK = 17'h00004,
        S_LK_PRV = 17'h00008,
        S_LK_DT  = 17'h00010,
        S_LK_DIV = 17'h00020,
        S_LK_SQ  = 17'h00040,
        S_LK_SM  = 17'h00080,
        S_LK_MAG = 17'h00100,
        S_LK_FIN = 17'h00200,
        S_IN_CHK = 17'h00400,
        S_IN_MRG = 17'h00800,
        S_PR_RD  = 17'h01000,
        S_PR_CHK = 17'h02000,
        S_FULL   = 17'h04000,
        S_WR     = 17'h08000,
        S_DONE   = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.latch_item = 1'b1;
                    state_next     = S_DISP;
                end
            end
            S_DISP:
            begin
                case (st.cmd)
                    btot_pkg::CMD_QUERY:
                    begin
                        if (st.dflt_zero)
                            state_next = S_DONE;
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = btot_pkg::RD_TOP;
                            ctl.k_top  = 1'b1;
                            state_next = S_LK_CHK;
                        end
                    end
                    btot_pkg::CMD_INSERT:
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = btot_pkg::RD_TOP;
                        state_next = S_IN_CHK;
                    end
                    btot_pkg::CMD_CLEAR:
                    begin
                        ctl.clear_tab = 1'b1;
                        state_next    = S_DONE;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_LK_CHK:
            begin
                if (st.k_zero || !st.rd_after)
                begin
                    ctl.off_from_rd = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    ctl.cur_load = 1'b1;
                    ctl.rd_en    = 1'b1;
                    ctl.rd_sel   = btot_pkg::RD_BELOW;
                    ctl.k_dec    = 1'b1;
                    state_next   = S_LK_PRV;
                end
            end
            S_LK_PRV:
            begin
                if (st.rd_after)
                begin
                    if (st.k_zero)
                    begin
                        ctl.off_from_rd = 1'b1;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ctl.cur_load = 1'b1;
                        ctl.rd_en    = 1'b1;
                        ctl.rd_sel   = btot_pkg::RD_BELOW;
                        ctl.k_dec    = 1'b1;
                    end
                end
                else
                begin
                    ctl.prv_load = 1'b1;
                    state_next   = S_LK_DT;
                end
            end
            S_LK_DT:
            begin
                if (st.dt_ge_r)
                begin
                    ctl.off_from_prv = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_LK_DIV;
                end
            end
            S_LK_DIV:
            begin
                if (st.div_done)
                begin
                    ctl.u_load = 1'b1;
                    state_next = S_LK_SQ;
                end
            end
            S_LK_SQ:
            begin
                ctl.u2_load = 1'b1;
                state_next  = S_LK_SM;
            end
            S_LK_SM:
            begin
                ctl.sm_load = 1'b1;
                state_next  = S_LK_MAG;
            end
            S_LK_MAG:
            begin
                ctl.prod_load = 1'b1;
                state_next    = S_LK_FIN;
            end
            S_LK_FIN:
            begin
                ctl.off_blend = 1'b1;
                state_next    = S_DONE;
            end
            S_IN_CHK:
            begin
                if (st.tgt_eq)
                    state_next = S_DONE;
                else
                    state_next = S_IN_MRG;
            end
            S_IN_MRG:
            begin
                if (st.cnt_le1 || st.mrg_stop)
                    state_next = S_PR_RD;
                else if (st.mrg_flushed)
                begin
                    ctl.ramp_short = 1'b1;
                    state_next     = S_PR_RD;
                end
                else
                begin
                    ctl.cnt_dec = 1'b1;
                    ctl.rd_en   = 1'b1;
                    ctl.rd_sel  = btot_pkg::RD_NEXT_TOP;
                end
            end
            S_PR_RD:
            begin
                if (st.cnt_le1)
                    state_next = S_FULL;
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = btot_pkg::RD_SECOND;
                    state_next = S_PR_CHK;
                end
            end
            S_PR_CHK:
            begin
                if (st.prune)
                begin
                    ctl.drop_old = 1'b1;
                    state_next   = S_PR_RD;
                end
                else
                    state_next = S_FULL;
            end
            S_FULL:
            begin
                if (st.full)
                begin
                    ctl.drop_old    = 1'b1;
                    ctl.set_dropped = 1'b1;
                end
                state_next = S_WR;
            end
            S_WR:
            begin
                ctl.write_new = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/btot_dp.sv]
// milestone table, pointers, blend arithmetic and result register
// depends on btot_pkg and btot_div
module btot_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [btot_pkg::RAMP_W-1:0]    cfg_wdata,
    input  logic [1:0]                     in_cmd,
    input  logic [btot_pkg::TIME_W-1:0]    in_time,
    input  logic signed [btot_pkg::TGT_W-1:0] in_target,
    input  logic [btot_pkg::RAMP_W-1:0]    in_ramp,
    input  logic [btot_pkg::TIME_W-1:0]    in_flush,
    input  btot_pkg::ctrl_t                ctl,
    output btot_pkg::stat_t                st,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [btot_pkg::TGT_W-1:0] out_offset,
    output logic                           out_dropped,
    output logic [btot_pkg::CNT_W-1:0]     out_entries
);

    localparam int TW = btot_pkg::TIME_W;
    localparam int RW = btot_pkg::RAMP_W;
    localparam int GW = btot_pkg::TGT_W;
    localparam int SB = btot_pkg::SM_BITS;
    localparam int IW = btot_pkg::IDX_W;
    localparam int CW = btot_pkg::CNT_W;

    btot_pkg::entry_t mem [btot_pkg::DEPTH];
    btot_pkg::entry_t rd_data_reg, rd_ent, cur_reg, prv_reg, wr_ent;

    logic [RW-1:0]     dflt_reg;
    logic [1:0]        cmd_reg;
    logic [TW-1:0]     t_reg, flush_reg;
    logic signed [GW-1:0] tgt_reg;
    logic [RW-1:0]     ramp_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     oldest_reg, oldest_next;
    logic [CW-1:0]     k_reg;
    logic              zpend_reg, zpend_next;
    logic              rd_zero_reg;
    logic signed [GW-1:0] off_reg;
    logic              drop_reg;
    logic              ovalid_reg;
    logic signed [GW-1:0] ooff_reg;
    logic              odrop_reg;
    logic [CW-1:0]     oent_reg;

    logic [SB-1:0]     u_reg, u2_reg, quot;
    logic [SB:0]       sm_reg;
    logic [GW:0]       mag_reg;
    logic              neg_reg;
    logic [63:0]       prod_reg;
    logic              div_busy;

    logic [CW-1:0]     rd_idx;
    logic [IW-1:0]     rd_addr, wr_addr;
    logic [RW-1:0]     r_eff, n_val, short_ramp;
    logic [TW-1:0]     dt, t_diff;
    logic [2*SB-1:0]   sq;
    logic [SB+1:0]     w_val;
    logic [2*SB+1:0]   smp;
    logic [GW:0]       delta;
    logic [64:0]       q_sum;
    logic [GW-1:0]     q_val;

    always_comb
    begin
        case (ctl.rd_sel)
            btot_pkg::RD_TOP:      rd_idx = count_reg - 1'b1;
            btot_pkg::RD_BELOW:    rd_idx = k_reg - 1'b1;
            btot_pkg::RD_NEXT_TOP: rd_idx = count_reg - CW'(2);
            btot_pkg::RD_SECOND:   rd_idx = CW'(1);
            default:               rd_idx = '0;
        endcase
        rd_addr = oldest_reg + rd_idx[IW-1:0];
        wr_addr = oldest_reg + count_reg[IW-1:0];
        rd_ent  = rd_zero_reg ? '0 : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_addr];
        if (ctl.write_new)
            mem[wr_addr] <= wr_ent;
    end

    assign wr_ent = '{target: tgt_reg, tstamp: t_reg, ramp: ramp_reg};

    // status toward the sequencer
    always_comb
    begin
        r_eff      = (cur_reg.ramp != '0) ? cur_reg.ramp : dflt_reg;
        dt         = cur_reg.tstamp - t_reg;
        n_val      = r_eff - dt[RW-1:0];
        t_diff     = t_reg - rd_ent.tstamp;
        short_ramp = (t_reg <= rd_ent.tstamp) ? RW'(1) : t_diff[RW-1:0];
        st.cmd         = cmd_reg;
        st.dflt_zero   = dflt_reg == '0;
        st.k_zero      = k_reg == '0;
        st.rd_after    = rd_ent.tstamp > t_reg;
        st.tgt_eq      = rd_ent.target == tgt_reg;
        st.dt_ge_r     = dt >= TW'(r_eff);
        st.cnt_le1     = count_reg <= CW'(1);
        st.mrg_stop    = !({1'b0, t_reg} <
                           ({1'b0, rd_ent.tstamp} + (TW+1)'(ramp_reg)));
        st.mrg_flushed = {1'b0, rd_ent.tstamp} < ({1'b0, flush_reg} + (TW+1)'(rd_ent.ramp));
        st.prune       = ({1'b0, rd_ent.tstamp} + (TW+1)'(dflt_reg)) < {1'b0, flush_reg};
        st.full        = count_reg >= CW'(btot_pkg::DEPTH);
        st.div_done    = !div_busy;
        st.out_free    = !ovalid_reg || out_ready;
    end

    btot_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (n_val),
        .den   (r_eff),
        .busy  (div_busy),
        .quot  (quot)
    );

    // smoothstep and blend arithmetic
    always_comb
    begin
        sq    = u_reg * u_reg;
        w_val = (SB+2)'(3) << SB;
        w_val = w_val - {1'b0, u_reg, 1'b0};
        smp   = u2_reg * w_val;
        delta = {cur_reg.target[GW-1], cur_reg.target} - {prv_reg.target[GW-1], prv_reg.target};
        q_sum = {1'b0, prod_reg} + (65'd1 << (SB - 1));
        q_val = q_sum[SB+GW-1:SB];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_item)
        begin
            cmd_reg   <= in_cmd;
            t_reg     <= in_time;
            tgt_reg   <= in_target;
            ramp_reg  <= in_ramp;
            flush_reg <= in_flush;
        end
        else if (ctl.ramp_short)
            ramp_reg <= short_ramp;
        if (ctl.cur_load)
            cur_reg <= rd_ent;
        if (ctl.prv_load)
            prv_reg <= rd_ent;
        if (ctl.u_load)
            u_reg <= quot;
        if (ctl.u2_load)
        begin
            u2_reg  <= sq[2*SB-1:SB];
            neg_reg <= delta[GW];
            mag_reg <= delta[GW] ? -delta : delta;
        end
        if (ctl.sm_load)
            sm_reg <= smp[2*SB:SB];
        if (ctl.prod_load)
            prod_reg <= {31'd0, mag_reg} * {33'd0, sm_reg};
        if (ctl.out_load)
        begin
            ooff_reg  <= off_reg;
            odrop_reg <= drop_reg;
            oent_reg  <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_item)
        begin
            off_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            if (ctl.off_from_rd)
                off_reg <= rd_ent.target;
            else if (ctl.off_from_prv)
                off_reg <= prv_reg.target;
            else if (ctl.off_blend)
                off_reg <= neg_reg ? prv_reg.target - q_val : prv_reg.target + q_val;
            if (ctl.set_dropped)
                drop_reg <= 1'b1;
        end
    end

    // table pointers
    always_comb
    begin
        count_next  = count_reg;
        oldest_next = oldest_reg;
        zpend_next  = zpend_reg;
        if (ctl.clear_tab)
        begin
            count_next  = CW'(1);
            oldest_next = '0;
            zpend_next  = 1'b1;
        end
        else if (ctl.cnt_dec)
            count_next = count_reg - 1'b1;
        else if (ctl.drop_old)
        begin
            count_next  = count_reg - 1'b1;
            oldest_next = oldest_reg + 1'b1;
        end
        else if (ctl.write_new)
        begin
            count_next = count_reg + 1'b1;
            if (wr_addr == '0)
                zpend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_reg    <= '0;
            count_reg   <= CW'(1);
            oldest_reg  <= '0;
            zpend_reg   <= 1'b1;
            rd_zero_reg <= 1'b0;
            k_reg       <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                dflt_reg <= cfg_wdata;
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            zpend_reg  <= zpend_next;
            if (ctl.rd_en)
                rd_zero_reg <= zpend_reg && (rd_addr == '0);
            if (ctl.k_top)
                k_reg <= count_reg - 1'b1;
            else if (ctl.k_dec)
                k_reg <= k_reg - 1'b1;
            if (ctl.out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_offset  = ooff_reg;
    assign out_dropped = odrop_reg;
    assign out_entries = oent_reg;

endmodule

[rtl/core/btot_chk.sv]
// port-level checker for the backlash offset table, bound to the top level
// depends on btot_pkg and assert_macros.svh
`include "assert_macros.svh"

module btot_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    `BTOT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    `BTOT_ASSERT_IMPL(a_entries_range, clk, rst_n, m_axis_tvalid, (m_axis_tdata[37:33] != 5'd0) && (m_axis_tdata[37:33] <= 5'(btot_pkg::DEPTH)))

    `BTOT_ASSERT_IMPL(a_drop_when_full, clk, rst_n, m_axis_tvalid && m_axis_tdata[32], (m_axis_tdata[37:33] == 5'(btot_pkg::DEPTH)) && (m_axis_tdata[31:0] == 32'd0))

    `BTOT_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind backlash_takeup_offset_table btot_chk u_chk (.*);
